@@ rtl/core/ddwsl_pkg.sv @@
// ----------------------------------------------------------------------------
// ddwsl_pkg
// Shared widths, register codes and reset values of the wheel speed limiter.
// ----------------------------------------------------------------------------
package ddwsl_pkg;

  localparam int unsigned DataW = 32;  // signed Q16.16 speeds
  localparam int unsigned DiamW = 20;
  localparam int unsigned AxleW = 20;
  localparam int unsigned MaxW  = 23;
  localparam int unsigned TolW  = 17;
  localparam int unsigned CfgW  = 23;  // widest register
  localparam int unsigned IdxW  = 2;

  localparam logic [IdxW-1:0] RegWheelDiameter = 2'd0;
  localparam logic [IdxW-1:0] RegAxleLength    = 2'd1;
  localparam logic [IdxW-1:0] RegMaxWheelSpeed = 2'd2;
  localparam logic [IdxW-1:0] RegEqualTol      = 2'd3;

  localparam logic [DiamW-1:0] DiamRst = 20'd12452;
  localparam logic [AxleW-1:0] AxleRst = 20'd24904;
  localparam logic [MaxW-1:0]  MaxRst  = 23'd350009;
  localparam logic [TolW-1:0]  TolRst  = 17'd66;

endpackage

@@ rtl/core/ddwsl_cmd_if.sv @@
// ----------------------------------------------------------------------------
// ddwsl_cmd_if
// Command channel: requested linear speed and turn rate.
// ----------------------------------------------------------------------------
interface ddwsl_cmd_if import ddwsl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] linear_speed;
  logic [DataW-1:0] turn_rate;

  modport source (output valid, linear_speed, turn_rate, input ready);
  modport sink   (input valid, linear_speed, turn_rate, output ready);
endinterface

@@ rtl/core/ddwsl_res_if.sv @@
// ----------------------------------------------------------------------------
// ddwsl_res_if
// Result channel: limited linear speed and turn rate.
// ----------------------------------------------------------------------------
interface ddwsl_res_if import ddwsl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] limited_linear_speed;
  logic [DataW-1:0] limited_turn_rate;

  modport source (output valid, limited_linear_speed, limited_turn_rate, input ready);
  modport sink   (input valid, limited_linear_speed, limited_turn_rate, output ready);
endinterface

@@ rtl/core/diff_drive_wheel_speed_limiter.sv @@
// ----------------------------------------------------------------------------
// diff_drive_wheel_speed_limiter
// Converts a (v, w) command to wheel speeds, clamps them keeping the wheel
// ratio, and converts back. Fully pipelined, one command per cycle unless stalled.
// ----------------------------------------------------------------------------
// channel  dir  handshake     payload
// cmd_i    in   valid/ready   linear_speed, turn_rate
// res_o    out  valid/ready   limited_linear_speed, limited_turn_rate
// cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// Takes one request per cycle while the skid register is empty.
// The pipeline is three one-bit-per-stage dividers (52, 61 and 45 stages)
// plus eleven arithmetic stages and the output register.
// Reset clears all valid bits and loads the register defaults.
// A skid register behind the output register absorbs one result; the
// pipeline freezes only while the skid register is full.
// ----------------------------------------------------------------------------
module diff_drive_wheel_speed_limiter import ddwsl_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  ddwsl_cmd_if.sink       cmd_i,
  ddwsl_res_if.source     res_o
);

  localparam int unsigned AwW      = AxleW + DataW + 1;
  localparam int unsigned NlW      = AwW + 1;
  localparam int unsigned NumW     = NlW - 2;          // |nl| < 2^52
  localparam int unsigned NormW    = 38;
  localparam int unsigned ShW      = $clog2(NumW - NormW + 1);
  localparam int unsigned VShift   = 17;
  localparam int unsigned OutShift = 18;
  localparam int unsigned ApLoW    = 32;
  localparam int unsigned LoW      = MaxW + ApLoW;
  localparam int unsigned HiW      = MaxW + NormW - ApLoW;
  localparam int unsigned ProdW    = MaxW + NormW;
  localparam int unsigned WhW      = MaxW + 1;
  localparam int unsigned SumW     = WhW + 1;
  localparam int unsigned P3W      = DiamW + SumW;
  localparam int unsigned TwoAW    = AxleW + 1;
  localparam int unsigned Div1N    = NumW;
  localparam int unsigned Div2N    = ProdW;
  localparam int unsigned Div3N    = P3W;

  typedef struct packed {
    logic [DataW-1:0] v;
    logic [AwW-1:0]   aw;
    logic             wnear;
  } sa_t;

  typedef struct packed {
    logic [NlW-1:0] nl;
    logic [NlW-1:0] nr;
    logic           wnear;
  } sb_t;

  typedef struct packed {
    logic            sgn_l;
    logic            sgn_r;
    logic [NumW-1:0] mag_l;
    logic [NumW-1:0] mag_r;
    logic            wnear;
  } sm_t;

  typedef struct packed {
    logic [DiamW-1:0] rem_l;
    logic [DiamW-1:0] rem_r;
    logic [NumW-1:0]  wk_l;
    logic [NumW-1:0]  wk_r;
    logic             wnear;
    logic             sgn_l;
    logic             sgn_r;
    logic             keep_l;
    logic [NormW-1:0] np_l;
    logic [NormW-1:0] np_r;
  } div1_t;

  typedef struct packed {
    logic [MaxW-1:0]  ql;
    logic [MaxW-1:0]  qr;
    logic             cut_l;
    logic             cut_r;
    logic             wnear;
    logic             sgn_l;
    logic             sgn_r;
    logic             keep_l;
    logic [NormW-1:0] np_l;
    logic [NormW-1:0] np_r;
  } sc_t;

  typedef struct packed {
    logic [WhW-1:0]   lt_s;
    logic [WhW-1:0]   rt_s;
    logic             pass;
    logic             kl;
    logic             neg;
    logic [MaxW-1:0]  at;
    logic [NormW-1:0] ap;
    logic [NormW-1:0] aq;
  } sd_t;

  typedef struct packed {
    logic [LoW-1:0]   lo;
    logic [HiW-1:0]   hi;
    logic [NormW-1:0] aq;
    logic [WhW-1:0]   lt_s;
    logic [WhW-1:0]   rt_s;
    logic             pass;
    logic             kl;
    logic             neg;
  } se_t;

  typedef struct packed {
    logic [ProdW-1:0] num;
    logic [NormW-1:0] aq;
    logic [WhW-1:0]   lt_s;
    logic [WhW-1:0]   rt_s;
    logic             pass;
    logic             kl;
    logic             neg;
  } sf_t;

  typedef struct packed {
    logic [NormW-1:0] rem;
    logic [ProdW-1:0] wk;
    logic [NormW-1:0] dv;
    logic [WhW-1:0]   lt_s;
    logic [WhW-1:0]   rt_s;
    logic             pass;
    logic             kl;
    logic             neg;
  } div2_t;

  typedef struct packed {
    logic [WhW-1:0] fl;
    logic [WhW-1:0] fr;
  } sg_t;

  typedef struct packed {
    logic            sgn_s;
    logic            sgn_d;
    logic [SumW-1:0] mag_s;
    logic [SumW-1:0] mag_d;
  } sh_t;

  typedef struct packed {
    logic           sgn_s;
    logic           sgn_d;
    logic [P3W-1:0] p0;
    logic [P3W-1:0] p1;
  } si_t;

  typedef struct packed {
    logic [TwoAW-1:0] rem;
    logic [P3W-1:0]   wk;
    logic             sgn_d;
    logic [DataW-1:0] out0;
  } div3_t;

  typedef struct packed {
    logic [DataW-1:0] out0;
    logic [DataW-1:0] out1;
  } res_t;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [DiamW-1:0] diam_q;
  logic [AxleW-1:0] axle_q;
  logic [MaxW-1:0]  max_q;
  logic [TolW-1:0]  tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diam_q <= DiamRst;
      axle_q <= AxleRst;
      max_q  <= MaxRst;
      tol_q  <= TolRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWheelDiameter: diam_q <= cfg_data_i[DiamW-1:0];
        RegAxleLength:    axle_q <= cfg_data_i[AxleW-1:0];
        RegMaxWheelSpeed: max_q  <= cfg_data_i[MaxW-1:0];
        RegEqualTol:      tol_q  <= cfg_data_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  logic [DiamW-1:0] d_eff;
  logic [AxleW-1:0] a_eff;
  logic [TwoAW-1:0] two_a;
  logic [MaxW:0]    mt;
  logic             tol_zero;

  assign d_eff    = (diam_q == '0) ? DiamW'(1) : diam_q;
  assign a_eff    = (axle_q == '0) ? AxleW'(1) : axle_q;
  assign two_a    = {a_eff, 1'b0};
  assign mt       = (MaxW+1)'(max_q) + (MaxW+1)'(tol_q);
  assign tol_zero = (tol_q == '0);

  // --------------------------------------------------------------------------
  // Divider steps (restoring, one quotient bit)
  // --------------------------------------------------------------------------
  function automatic div1_t div1_step(div1_t x, logic [DiamW-1:0] dv);
    div1_t          y;
    logic [DiamW:0] tl;
    logic [DiamW:0] tr;
    y  = x;
    tl = {x.rem_l, x.wk_l[NumW-1]};
    tr = {x.rem_r, x.wk_r[NumW-1]};
    if (tl >= {1'b0, dv}) begin
      y.rem_l = DiamW'(tl - {1'b0, dv});
      y.wk_l  = {x.wk_l[NumW-2:0], 1'b1};
    end else begin
      y.rem_l = tl[DiamW-1:0];
      y.wk_l  = {x.wk_l[NumW-2:0], 1'b0};
    end
    if (tr >= {1'b0, dv}) begin
      y.rem_r = DiamW'(tr - {1'b0, dv});
      y.wk_r  = {x.wk_r[NumW-2:0], 1'b1};
    end else begin
      y.rem_r = tr[DiamW-1:0];
      y.wk_r  = {x.wk_r[NumW-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic div2_t div2_step(div2_t x);
    div2_t          y;
    logic [NormW:0] t;
    y = x;
    t = {x.rem, x.wk[ProdW-1]};
    if (t >= {1'b0, x.dv}) begin
      y.rem = NormW'(t - {1'b0, x.dv});
      y.wk  = {x.wk[ProdW-2:0], 1'b1};
    end else begin
      y.rem = t[NormW-1:0];
      y.wk  = {x.wk[ProdW-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic div3_t div3_step(div3_t x, logic [TwoAW-1:0] dv);
    div3_t          y;
    logic [TwoAW:0] t;
    y = x;
    t = {x.rem, x.wk[P3W-1]};
    if (t >= {1'b0, dv}) begin
      y.rem = TwoAW'(t - {1'b0, dv});
      y.wk  = {x.wk[P3W-2:0], 1'b1};
    end else begin
      y.rem = t[TwoAW-1:0];
      y.wk  = {x.wk[P3W-2:0], 1'b0};
    end
    return y;
  endfunction

  // --------------------------------------------------------------------------
  // Flow control
  // --------------------------------------------------------------------------
  logic pipe_en;
  logic out_valid_q;
  logic skid_valid_q;
  res_t out_q;
  res_t skid_q;

  assign pipe_en     = !skid_valid_q;
  assign cmd_i.ready = pipe_en;

  // --------------------------------------------------------------------------
  // Stage A: L*w and near-zero test on w
  // --------------------------------------------------------------------------
  logic             sa_v_q;
  sa_t              sa_q;
  logic [AwW-1:0]   aw_c;
  logic [DataW-1:0] wmag_c;

  assign aw_c   = $signed({1'b0, a_eff}) * $signed(cmd_i.turn_rate);
  assign wmag_c = cmd_i.turn_rate[DataW-1] ? (~cmd_i.turn_rate + 1'b1) : cmd_i.turn_rate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sa_v_q <= 1'b0;
    else if (pipe_en) sa_v_q <= cmd_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sa_q.v     <= cmd_i.linear_speed;
      sa_q.aw    <= aw_c;
      sa_q.wnear <= (wmag_c < DataW'(tol_q));
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: wheel numerators 2v*2^16 -/+ L*w
  // --------------------------------------------------------------------------
  logic           sb_v_q;
  sb_t            sb_q;
  logic [NlW-1:0] vs_c;
  logic [NlW-1:0] aws_c;

  assign vs_c  = {{(NlW-DataW-VShift){sa_q.v[DataW-1]}}, sa_q.v, {VShift{1'b0}}};
  assign aws_c = {{(NlW-AwW){sa_q.aw[AwW-1]}}, sa_q.aw};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sb_v_q <= 1'b0;
    else if (pipe_en) sb_v_q <= sa_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sb_q.nl    <= vs_c - aws_c;
      sb_q.nr    <= vs_c + aws_c;
      sb_q.wnear <= sa_q.wnear;
    end
  end

  // --------------------------------------------------------------------------
  // Stage M: sign / magnitude of the numerators
  // --------------------------------------------------------------------------
  logic           sm_v_q;
  sm_t            sm_q;
  logic [NlW-1:0] nl_neg_c;
  logic [NlW-1:0] nr_neg_c;

  assign nl_neg_c = ~sb_q.nl + 1'b1;
  assign nr_neg_c = ~sb_q.nr + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sm_v_q <= 1'b0;
    else if (pipe_en) sm_v_q <= sb_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sm_q.sgn_l <= sb_q.nl[NlW-1];
      sm_q.sgn_r <= sb_q.nr[NlW-1];
      sm_q.mag_l <= sb_q.nl[NlW-1] ? nl_neg_c[NumW-1:0] : sb_q.nl[NumW-1:0];
      sm_q.mag_r <= sb_q.nr[NlW-1] ? nr_neg_c[NumW-1:0] : sb_q.nr[NumW-1:0];
      sm_q.wnear <= sb_q.wnear;
    end
  end

  // --------------------------------------------------------------------------
  // Divider 1: |nl| / D and |nr| / D; ratio operands normalized alongside
  // --------------------------------------------------------------------------
  logic [NumW-1:0] nx_c;
  logic [ShW-1:0]  sh_c;
  div1_t           d1_init;

  assign nx_c = sm_q.mag_l | sm_q.mag_r;

  // halve both until each is below 2^38: shift by the excess of the top bit
  always_comb begin
    sh_c = '0;
    for (int i = NormW; i < NumW; i++) begin
      if (nx_c[i]) sh_c = ShW'(i - NormW + 1);
    end
  end

  always_comb begin
    d1_init        = '0;
    d1_init.wk_l   = sm_q.mag_l;
    d1_init.wk_r   = sm_q.mag_r;
    d1_init.wnear  = sm_q.wnear;
    d1_init.sgn_l  = sm_q.sgn_l;
    d1_init.sgn_r  = sm_q.sgn_r;
    d1_init.keep_l = (sm_q.mag_l >= sm_q.mag_r);
    d1_init.np_l   = NormW'(sm_q.mag_l >> sh_c);
    d1_init.np_r   = NormW'(sm_q.mag_r >> sh_c);
  end

  logic  d1_v_q [Div1N];
  div1_t d1_q   [Div1N];

  for (genvar k = 0; k < Div1N; k++) begin : g_div1
    div1_t src;
    logic  src_v;
    if (k == 0) begin : g_first
      assign src   = d1_init;
      assign src_v = sm_v_q;
    end else begin : g_next
      assign src   = d1_q[k-1];
      assign src_v = d1_v_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) d1_v_q[k] <= 1'b0;
      else if (pipe_en) d1_v_q[k] <= src_v;
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) d1_q[k] <= div1_step(src, d_eff);
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: clamp wheels, detect cut wheels
  // --------------------------------------------------------------------------
  logic  sc_v_q;
  sc_t   sc_q;
  div1_t d1_last;

  assign d1_last = d1_q[Div1N-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sc_v_q <= 1'b0;
    else if (pipe_en) sc_v_q <= d1_v_q[Div1N-1];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sc_q.ql     <= (d1_last.wk_l > NumW'(max_q)) ? max_q : d1_last.wk_l[MaxW-1:0];
      sc_q.qr     <= (d1_last.wk_r > NumW'(max_q)) ? max_q : d1_last.wk_r[MaxW-1:0];
      // cut when the clamp removed at least the tolerance, or always when the tolerance is zero
      sc_q.cut_l  <= tol_zero || (d1_last.wk_l >= NumW'(mt));
      sc_q.cut_r  <= tol_zero || (d1_last.wk_r >= NumW'(mt));
      sc_q.wnear  <= d1_last.wnear;
      sc_q.sgn_l  <= d1_last.sgn_l;
      sc_q.sgn_r  <= d1_last.sgn_r;
      sc_q.keep_l <= d1_last.keep_l;
      sc_q.np_l   <= d1_last.np_l;
      sc_q.np_r   <= d1_last.np_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: pick kept wheel and ratio operands
  // --------------------------------------------------------------------------
  logic sd_v_q;
  sd_t  sd_q;
  logic tneg_l_c;
  logic tneg_r_c;
  logic kl_c;

  assign tneg_l_c = sc_q.sgn_l && (sc_q.ql != '0);
  assign tneg_r_c = sc_q.sgn_r && (sc_q.qr != '0);
  assign kl_c     = (sc_q.cut_l && sc_q.cut_r) ? sc_q.keep_l : sc_q.cut_l;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sd_v_q <= 1'b0;
    else if (pipe_en) sd_v_q <= sc_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sd_q.lt_s <= tneg_l_c ? (~{1'b0, sc_q.ql} + 1'b1) : {1'b0, sc_q.ql};
      sd_q.rt_s <= tneg_r_c ? (~{1'b0, sc_q.qr} + 1'b1) : {1'b0, sc_q.qr};
      sd_q.pass <= sc_q.wnear || !(sc_q.cut_l || sc_q.cut_r);
      sd_q.kl   <= kl_c;
      sd_q.neg  <= (kl_c ? tneg_l_c : tneg_r_c) ^ sc_q.sgn_l ^ sc_q.sgn_r;
      sd_q.at   <= kl_c ? sc_q.ql : sc_q.qr;
      sd_q.ap   <= kl_c ? sc_q.np_r : sc_q.np_l;
      sd_q.aq   <= kl_c ? sc_q.np_l : sc_q.np_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stages E/F: |t| * |p| as two partial products, then summed
  // --------------------------------------------------------------------------
  logic se_v_q;
  se_t  se_q;
  logic sf_v_q;
  sf_t  sf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      se_v_q <= 1'b0;
      sf_v_q <= 1'b0;
    end else if (pipe_en) begin
      se_v_q <= sd_v_q;
      sf_v_q <= se_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      se_q.lo   <= sd_q.at * sd_q.ap[ApLoW-1:0];
      se_q.hi   <= sd_q.at * sd_q.ap[NormW-1:ApLoW];
      se_q.aq   <= sd_q.aq;
      se_q.lt_s <= sd_q.lt_s;
      se_q.rt_s <= sd_q.rt_s;
      se_q.pass <= sd_q.pass;
      se_q.kl   <= sd_q.kl;
      se_q.neg  <= sd_q.neg;

      sf_q.num  <= ProdW'(se_q.lo) + {se_q.hi, {ApLoW{1'b0}}};
      sf_q.aq   <= se_q.aq;
      sf_q.lt_s <= se_q.lt_s;
      sf_q.rt_s <= se_q.rt_s;
      sf_q.pass <= se_q.pass;
      sf_q.kl   <= se_q.kl;
      sf_q.neg  <= se_q.neg;
    end
  end

  // --------------------------------------------------------------------------
  // Divider 2: derived wheel magnitude |t*p| / |q|
  // --------------------------------------------------------------------------
  div2_t d2_init;

  always_comb begin
    d2_init      = '0;
    d2_init.wk   = sf_q.num;
    d2_init.dv   = sf_q.aq;
    d2_init.lt_s = sf_q.lt_s;
    d2_init.rt_s = sf_q.rt_s;
    d2_init.pass = sf_q.pass;
    d2_init.kl   = sf_q.kl;
    d2_init.neg  = sf_q.neg;
  end

  logic  d2_v_q [Div2N];
  div2_t d2_q   [Div2N];

  for (genvar k = 0; k < Div2N; k++) begin : g_div2
    div2_t src;
    logic  src_v;
    if (k == 0) begin : g_first
      assign src   = d2_init;
      assign src_v = sf_v_q;
    end else begin : g_next
      assign src   = d2_q[k-1];
      assign src_v = d2_v_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) d2_v_q[k] <= 1'b0;
      else if (pipe_en) d2_v_q[k] <= src_v;
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) d2_q[k] <= div2_step(src);
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: clamp derived wheel, assemble final wheels
  // --------------------------------------------------------------------------
  logic            sg_v_q;
  sg_t             sg_q;
  div2_t           d2_last;
  logic [MaxW-1:0] der_c;
  logic [WhW-1:0]  der_s_c;

  assign d2_last = d2_q[Div2N-1];
  // zero divisor gives a zero wheel
  assign der_c   = (d2_last.dv == '0) ? '0 :
                   (d2_last.wk > ProdW'(max_q)) ? max_q : d2_last.wk[MaxW-1:0];
  assign der_s_c = (d2_last.neg && der_c != '0) ? (~{1'b0, der_c} + 1'b1) : {1'b0, der_c};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sg_v_q <= 1'b0;
    else if (pipe_en) sg_v_q <= d2_v_q[Div2N-1];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sg_q.fl <= (d2_last.pass || d2_last.kl) ? d2_last.lt_s : der_s_c;
      sg_q.fr <= (d2_last.pass || !d2_last.kl) ? d2_last.rt_s : der_s_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stage H: l+r and r-l as sign / magnitude
  // --------------------------------------------------------------------------
  logic            sh_v_q;
  sh_t             sh_q;
  logic [SumW-1:0] sum_c;
  logic [SumW-1:0] dif_c;

  assign sum_c = {sg_q.fl[WhW-1], sg_q.fl} + {sg_q.fr[WhW-1], sg_q.fr};
  assign dif_c = {sg_q.fr[WhW-1], sg_q.fr} - {sg_q.fl[WhW-1], sg_q.fl};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sh_v_q <= 1'b0;
    else if (pipe_en) sh_v_q <= sg_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sh_q.sgn_s <= sum_c[SumW-1];
      sh_q.sgn_d <= dif_c[SumW-1];
      sh_q.mag_s <= sum_c[SumW-1] ? (~sum_c + 1'b1) : sum_c;
      sh_q.mag_d <= dif_c[SumW-1] ? (~dif_c + 1'b1) : dif_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stage I: D * |l+r| and D * |r-l|
  // --------------------------------------------------------------------------
  logic si_v_q;
  si_t  si_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) si_v_q <= 1'b0;
    else if (pipe_en) si_v_q <= sh_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      si_q.sgn_s <= sh_q.sgn_s;
      si_q.sgn_d <= sh_q.sgn_d;
      si_q.p0    <= d_eff * sh_q.mag_s;
      si_q.p1    <= d_eff * sh_q.mag_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider 3: D*|r-l| / 2L; linear speed rides along
  // --------------------------------------------------------------------------
  div3_t            d3_init;
  logic [DataW-1:0] lin_mag_c;

  assign lin_mag_c = DataW'(si_q.p0[P3W-1:OutShift]);

  always_comb begin
    d3_init       = '0;
    d3_init.wk    = si_q.p1;
    d3_init.sgn_d = si_q.sgn_d;
    d3_init.out0  = si_q.sgn_s ? (~lin_mag_c + 1'b1) : lin_mag_c;
  end

  logic  d3_v_q [Div3N];
  div3_t d3_q   [Div3N];

  for (genvar k = 0; k < Div3N; k++) begin : g_div3
    div3_t src;
    logic  src_v;
    if (k == 0) begin : g_first
      assign src   = d3_init;
      assign src_v = si_v_q;
    end else begin : g_next
      assign src   = d3_q[k-1];
      assign src_v = d3_v_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) d3_v_q[k] <= 1'b0;
      else if (pipe_en) d3_v_q[k] <= src_v;
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) d3_q[k] <= div3_step(src, two_a);
    end
  end

  // --------------------------------------------------------------------------
  // Stage K: saturate turn rate
  // --------------------------------------------------------------------------
  logic  sk_v_q;
  res_t  sk_q;
  div3_t d3_last;
  logic  sat_neg_c;
  logic  sat_pos_c;

  assign d3_last   = d3_q[Div3N-1];
  assign sat_neg_c = (d3_last.wk[P3W-1:DataW] != '0) ||
                     (d3_last.wk[DataW-1] && (d3_last.wk[DataW-2:0] != '0));
  assign sat_pos_c = (d3_last.wk[P3W-1:DataW-1] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sk_v_q <= 1'b0;
    else if (pipe_en) sk_v_q <= d3_v_q[Div3N-1];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sk_q.out0 <= d3_last.out0;
      if (d3_last.sgn_d) begin
        sk_q.out1 <= sat_neg_c ? {1'b1, {(DataW-1){1'b0}}}
                               : (~d3_last.wk[DataW-1:0] + 1'b1);
      end else begin
        sk_q.out1 <= sat_pos_c ? {1'b0, {(DataW-1){1'b1}}} : d3_last.wk[DataW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (res_o.ready) skid_valid_q <= 1'b0;
    end else if (sk_v_q) begin
      if (out_valid_q && !res_o.ready) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (res_o.ready) out_q <= skid_q;
    end else if (sk_v_q) begin
      if (out_valid_q && !res_o.ready) skid_q <= sk_q;
      else out_q <= sk_q;
    end
  end

  assign res_o.valid                = out_valid_q;
  assign res_o.limited_linear_speed = out_q.out0;
  assign res_o.limited_turn_rate    = out_q.out1;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic [WhW-1:0] fl_abs;
  assign fl_abs = sg_q.fl[WhW-1] ? (~sg_q.fl + 1'b1) : sg_q.fl;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !res_o.ready |=> skid_valid_q)
    else $error("skid request lost while output stalled");

  a_stall_keeps_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en && sk_v_q |=> sk_v_q)
    else $error("last pipeline stage dropped a request during stall");

  a_wheel_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sg_v_q |-> (fl_abs <= {1'b0, max_q}))
    else $error("left wheel exceeds maximum wheel speed");

endmodule
